[rtl/core/crq_pkg.sv]
// Shared constants, payload types and cell control types for the C-LOOK request queue.
package crq_pkg;

  localparam int QueueDepth = 16;
  localparam int SectorBits = 48;
  localparam int TagBits    = 8;
  localparam int CountBits  = $clog2(QueueDepth + 1);

  // Result status codes.
  localparam logic [1:0] StAdded      = 2'd0;
  localparam logic [1:0] StFull       = 2'd1;
  localparam logic [1:0] StDispatched = 2'd2;
  localparam logic [1:0] StEmpty      = 2'd3;

  // Request type codes.
  localparam logic ReqAdd      = 1'b0;
  localparam logic ReqDispatch = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [SectorBits-1:0] req_sector;
    logic                  req_write;
    logic [TagBits-1:0]    req_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [SectorBits-1:0] out_sector;
    logic                  out_write;
    logic [TagBits-1:0]    out_tag;
  } res_t;

  typedef struct packed {
    logic [SectorBits-1:0] sector;
    logic                  write;
    logic [TagBits-1:0]    tag;
  } entry_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic                  cmp_en;
    logic                  add_en;
    logic                  pop_en;
    logic                  high;
    logic [SectorBits-1:0] head;
    entry_t                new_entry;
  } cell_ctrl_t;

endpackage

[rtl/core/crq_cell.sv]
// One queue slot: holds an entry, flags whether a new word belongs here, and shifts.
module crq_cell
  import crq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       occupied_i,
  input  logic       at_end_i,
  input  logic       found_i,
  input  entry_t     left_i,
  input  entry_t     right_i,
  output logic       found_o,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;
  logic   match_q, match_d;
  logic   below;
  logic   fits;

  // Placement test against the stored sector.
  assign below = entry_q.sector < ctrl_i.head;
  assign fits  = ctrl_i.new_entry.sector <= entry_q.sector;

  always_comb begin
    match_d = match_q;
    if (ctrl_i.cmp_en) begin
      match_d = at_end_i ||
                (occupied_i && (ctrl_i.high ? (below || fits) : (below && fits)));
    end
  end

  // The first matching cell takes the new word; every cell after it shifts right.
  assign found_o = found_i | match_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.add_en) begin
      if (found_i) begin
        entry_d = left_i;
      end else if (match_q) begin
        entry_d = ctrl_i.new_entry;
      end
    end else if (ctrl_i.pop_en) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[rtl/core/clook_request_queue_top.sv]
// Top level of the C-LOOK disk request queue: sequencer, head position and chain of slots.
//
// A word is accepted when start is high and busy is low. Every word, add or dispatch,
// is first latched; then every slot compares its sector with the new one and the
// head; then the slots shift and insert or pop.
// Busy stays high through the compare and apply steps, so no new word is taken until
// the previous one is through. The result appears on res_o for exactly one cycle, marked by
// result_valid_o, in the cycle busy falls; the receiver cannot hold it off. The queue
// holds sixteen entries; slot contents are undefined until written, and only occupied
// slots are ever read.
module clook_request_queue_top
  import crq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic result_valid_o,
  output res_t res_o
);

  typedef enum logic [1:0] {
    StIdle,
    StCompare,
    StApply
  } state_e;

  state_e                state_q, state_d;
  req_t                  cmd_q, cmd_d;
  logic [CountBits-1:0]  count_q, count_d;
  logic [SectorBits-1:0] head_q, head_d;
  res_t                  res_q, res_d;
  logic                  res_valid_q, res_valid_d;

  cell_ctrl_t ctrl;
  logic       is_full;
  logic       is_empty;
  entry_t     entry_w [QueueDepth];
  logic       found_w [QueueDepth+1];

  assign is_full  = count_q == CountBits'(QueueDepth);
  assign is_empty = count_q == '0;

  // Control broadcast to the slots.
  always_comb begin
    ctrl.cmp_en           = state_q == StCompare;
    ctrl.add_en           = (state_q == StApply) && (cmd_q.req_type == ReqAdd) && !is_full;
    ctrl.pop_en           = (state_q == StApply) && (cmd_q.req_type == ReqDispatch) &&
                            !is_empty;
    ctrl.high             = cmd_q.req_sector >= head_q;
    ctrl.head             = head_q;
    ctrl.new_entry.sector = cmd_q.req_sector;
    ctrl.new_entry.write  = cmd_q.req_write;
    ctrl.new_entry.tag    = cmd_q.req_tag;
  end

  // Chain of slots; the found flag ripples from the front toward the back.
  assign found_w[0] = 1'b0;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    entry_t left;
    entry_t right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_left
      assign left = entry_w[i-1];
    end

    if (i == QueueDepth - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_right
      assign right = entry_w[i+1];
    end

    crq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .occupied_i (CountBits'(i) < count_q),
      .at_end_i   (CountBits'(i) == count_q),
      .found_i    (found_w[i]),
      .left_i     (left),
      .right_i    (right),
      .found_o    (found_w[i+1]),
      .entry_o    (entry_w[i])
    );
  end

  // Sequencer, counters and result register.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    count_d     = count_q;
    head_d      = head_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_d   = req_i;
          state_d = StCompare;
        end
      end
      StCompare: begin
        state_d = StApply;
      end
      StApply: begin
        state_d     = StIdle;
        res_valid_d = 1'b1;
        res_d       = '0;
        if (cmd_q.req_type == ReqAdd) begin
          if (is_full) begin
            res_d.status = StFull;
          end else begin
            res_d.status = StAdded;
            count_d      = count_q + 1'b1;
          end
        end else begin
          if (is_empty) begin
            res_d.status = StEmpty;
          end else begin
            res_d.status     = StDispatched;
            res_d.out_sector = entry_w[0].sector;
            res_d.out_write  = entry_w[0].write;
            res_d.out_tag    = entry_w[0].tag;
            head_d           = entry_w[0].sector;
            count_d          = count_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      head_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  assign busy           = state_q != StIdle;
  assign result_valid_o = res_valid_q;
  assign res_o          = res_q;

endmodule
